[design/ifr_pkg.sv]
// Shared types and constants for the IPv4 fragment reassembly tracker.
// No dependencies.
package ifr_pkg;

  localparam int DEF_CONTEXTS = 16;
  localparam int DEF_SPANS    = 16;

  localparam logic [31:0] TIMEOUT_RST   = 32'd30000;
  localparam logic [4:0]  MAX_CTX_RST   = 5'd16;
  localparam logic [4:0]  MAX_FRAGS_RST = 5'd16;

  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_MAX_CTX   = 2'd1;
  localparam logic [1:0] REG_MAX_FRAGS = 2'd2;

  localparam logic [2:0] V_STORED    = 3'd0;
  localparam logic [2:0] V_TRIMMED   = 3'd1;
  localparam logic [2:0] V_DUP       = 3'd2;
  localparam logic [2:0] V_NO_CTX    = 3'd3;
  localparam logic [2:0] V_FLUSH     = 3'd4;
  localparam logic [2:0] V_REPEAT    = 3'd5;
  localparam logic [2:0] V_COMPLETE  = 3'd6;
  localparam logic [2:0] V_TICK      = 3'd7;

  // stored interval; span_start sits in the low bits
  typedef struct packed {
    logic [4:0]  cnt;
    logic [15:0] span_end;
    logic [15:0] span_start;
  } span_t;

  typedef struct packed {
    logic [15:0] cs;
    logic [15:0] ce;
    logic        has_prev;
    logic [15:0] pe;
    span_t       prv;
    logic        has_next;
    logic [15:0] ns;
    span_t       nxt;
  } plan_in_t;

  typedef struct packed {
    logic        direct;
    logic        dup;
    logic        trimmed;
    logic        mprev;
    logic        mnext;
    logic [15:0] kcs;
    logic [15:0] kce;
    span_t       m;
  } plan_t;

endpackage

[design/ifr_trim_unit.sv]
// Trim, duplicate and merge decision for one fragment against its neighbors.
// Depends on ifr_pkg.
module ifr_trim_unit (
  input  ifr_pkg::plan_in_t pin,
  output ifr_pkg::plan_t    pout
);

  always_comb begin
    pout = '0;
    pout.kcs = pin.cs;
    pout.kce = pin.ce;
    pout.direct = (pin.cs > pin.pe) && (!pin.has_next || pin.ce < pin.ns);
    if (!pout.direct) begin
      if (pin.has_next && pin.ns < pin.ce) begin
        if (pin.ns <= pin.cs) begin
          pout.dup = 1'b1;
        end else begin
          pout.kce = pin.ns;
          pout.trimmed = 1'b1;
        end
      end
      if (!pout.dup && pin.pe > pin.cs) begin
        if (pin.pe >= pout.kce) begin
          pout.dup = 1'b1;
        end else begin
          pout.kcs = pin.pe;
          pout.trimmed = 1'b1;
        end
      end
    end
    pout.mprev = !pout.direct && pin.has_prev && pout.kcs == pin.pe;
    pout.mnext = !pout.direct && pin.has_next && pout.kce == pin.ns;
    if (pout.mprev && pout.mnext) begin
      pout.m.span_start = pin.prv.span_start;
      pout.m.span_end   = pin.nxt.span_end;
      pout.m.cnt        = pin.prv.cnt + 5'd1 + pin.nxt.cnt;
    end else if (pout.mprev) begin
      pout.m.span_start = pin.prv.span_start;
      pout.m.span_end   = pout.kce;
      pout.m.cnt        = pin.prv.cnt + 5'd1;
    end else if (pout.mnext) begin
      pout.m.span_start = pout.kcs;
      pout.m.span_end   = pin.nxt.span_end;
      pout.m.cnt        = pin.nxt.cnt + 5'd1;
    end else begin
      pout.m.span_start = pout.kcs;
      pout.m.span_end   = pout.kce;
      pout.m.cnt        = 5'd1;
    end
  end

endmodule

[design/ip_fragment_reassembly_tracker.sv]
// Top level of the IPv4 fragment reassembly tracker: context table, span memory, sequencer.
// Depends on ifr_pkg and ifr_trim_unit.
//
// One item at a time. A tick walks the context table one slot a cycle. A fragment
// walks the table the same way until its key matches, takes a decision step (which
// first allocates a new context if no key matched), reads its context's n stored
// spans from the span memory, plans trim and merge, writes back the new span list
// and then presents the result; a fragment that ends early (no context, flush,
// repeat, completion) skips the later steps. The result sits in an output register;
// the block waits with ready low until the previous result has been taken.
module ip_fragment_reassembly_tracker #(
  parameter int CONTEXTS          = ifr_pkg::DEF_CONTEXTS,
  parameter int SPANS_PER_CONTEXT = ifr_pkg::DEF_SPANS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_addr, dst_addr, ident, protocol, device, frag_offset, packet_len,
  // header_len, now_tick, zero pad
  input  logic [167:0] s_tdata,
  input  logic         s_tuser,    // command
  input  logic         s_tlast,    // last_frag
  output logic         m_tvalid,
  input  logic         m_tready,
  // kept_start, kept_end, total_len, context_index, expired_count, zero pad
  output logic [63:0]  m_tdata,
  output logic [2:0]   m_tuser,    // verdict
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int SPC   = SPANS_PER_CONTEXT;
  localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int IW    = $clog2(SPC);
  localparam int NW    = $clog2(SPC + 2);
  localparam int AW    = $clog2(CONTEXTS * SPC);
  localparam int OW    = $clog2(CONTEXTS + 1);
  localparam int RW    = NW + 5;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_TICK   = 8'b00000010,
    S_SEARCH = 8'b00000100,
    S_DECIDE = 8'b00001000,
    S_LOAD   = 8'b00010000,
    S_PLAN   = 8'b00100000,
    S_WRITE  = 8'b01000000,
    S_FIN    = 8'b10000000
  } state_t;

  state_t state;

  logic [31:0] timeout;
  logic [4:0]  max_ctx;
  logic [4:0]  max_frags;

  logic [95:0] key_r;
  logic [15:0] cs_r, ce_r;
  logic        last_r;
  logic [31:0] now_r;

  logic        ctx_valid [CONTEXTS];
  logic [95:0] ctx_key [CONTEXTS];
  logic        ctx_last_seen [CONTEXTS];
  logic [15:0] ctx_total [CONTEXTS];
  logic [4:0]  ctx_sum [CONTEXTS];
  logic [31:0] ctx_expiry [CONTEXTS];
  logic [NW-1:0] span_n [CONTEXTS];

  logic [CTX_W-1:0] sidx, cur, free_idx;
  logic             found, free_ok;
  logic [OW-1:0]    open_cnt, exp_cnt;

  logic [NW-1:0] n_old, ld_i, p, kb, j;
  logic [NW-1:0] rd_i;
  logic          rd_v, pfound;
  logic [RW-1:0] rem;
  ifr_pkg::span_t prv, nxt;
  ifr_pkg::span_t w_span [SPC];

  logic [NW-1:0] h_r, t_r, new_n_r;
  logic          hasm_r;
  ifr_pkg::span_t m_r;

  logic [2:0]  res_verdict;
  logic [15:0] res_ks, res_ke, res_tot;

  ifr_pkg::span_t span_mem [CONTEXTS * SPC];
  ifr_pkg::span_t mem_rdata, mem_wdata;
  logic [AW-1:0]  base, mem_raddr;
  logic           issue;

  ifr_pkg::plan_in_t pin;
  ifr_pkg::plan_t    pout;

  logic [15:0] in_len, in_ce;
  logic [16:0] in_sum;
  logic [NW-1:0] ne, h_c, t_c, new_n_c, kept_c;
  logic          hasm_c, full_c, check_c, complete_c;
  logic [4:0]    sum_base, sum_new;
  ifr_pkg::span_t first_c;
  logic [NW:0]   widx;
  logic [31:0]   cur32, exp32;

  // fragment payload extent
  always_comb begin
    in_len = (s_tdata[127:112] > {10'd0, s_tdata[133:128]}) ?
             s_tdata[127:112] - {10'd0, s_tdata[133:128]} : 16'd0;
    in_sum = {1'b0, s_tdata[111:96]} + {1'b0, in_len};
    in_ce  = in_sum[16] ? 16'hFFFF : in_sum[15:0];
  end

  assign base      = AW'(cur) * AW'(SPC);
  assign issue     = (state == S_LOAD) && (ld_i < n_old);
  assign mem_raddr = base + AW'(ld_i);
  assign ne        = last_r ? p : n_old;

  always_comb begin
    pin.cs       = cs_r;
    pin.ce       = ce_r;
    pin.has_prev = kb != '0;
    pin.pe       = (kb != '0) ? prv.span_end : 16'd0;
    pin.prv      = prv;
    pin.has_next = p < ne;
    pin.ns       = (p < ne) ? nxt.span_start : 16'd0;
    pin.nxt      = nxt;
  end

  ifr_trim_unit u_trim (
    .pin  (pin),
    .pout (pout)
  );

  // new list = old[0..h-1], optional merged/new span, old[t..ne-1]
  always_comb begin
    h_c = kb;
    t_c = p;
    if (!pout.dup && pout.mprev) h_c = kb - NW'(1);
    if (!pout.dup && pout.mnext) t_c = p + NW'(1);
    hasm_c  = !pout.dup;
    kept_c  = kb + ne - p;
    full_c  = !pout.dup && !pout.mprev && !pout.mnext && (32'(kept_c) >= 32'(SPC));
    new_n_c = h_c + NW'(hasm_c) + (ne - t_c);
    sum_base = (RW'(ctx_sum[cur]) > rem) ? 5'(RW'(ctx_sum[cur]) - rem) : 5'd0;
    sum_new  = sum_base + 5'(hasm_c && !full_c);
    check_c  = !pout.direct && !pout.dup && !full_c;
    if (h_c != '0) first_c = w_span[0];
    else if (hasm_c) first_c = pout.m;
    else first_c = nxt;
    complete_c = check_c && ctx_last_seen[cur] && new_n_c != '0 &&
                 first_c.span_start == 16'd0 && first_c.span_end == ctx_total[cur];
  end

  always_comb begin
    if (j < h_r) widx = {1'b0, j};
    else widx = (NW+1)'(t_r) + (NW+1)'(j) - (NW+1)'(h_r) - (NW+1)'(hasm_r);
    mem_wdata = (j == h_r && hasm_r) ? m_r : w_span[widx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    mem_rdata <= span_mem[mem_raddr];
    if (state == S_WRITE) begin
      span_mem[base + AW'(j)] <= mem_wdata;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign cur32 = 32'(cur);
  assign exp32 = 32'(exp_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      timeout   <= ifr_pkg::TIMEOUT_RST;
      max_ctx   <= ifr_pkg::MAX_CTX_RST;
      max_frags <= ifr_pkg::MAX_FRAGS_RST;
      rd_v      <= 1'b0;
      for (int i = 0; i < CONTEXTS; i++) ctx_valid[i] <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          ifr_pkg::REG_TIMEOUT:   timeout   <= cfg_wdata;
          ifr_pkg::REG_MAX_CTX:   max_ctx   <= cfg_wdata[4:0];
          ifr_pkg::REG_MAX_FRAGS: max_frags <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      rd_v <= issue;
      rd_i <= ld_i;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            key_r    <= s_tdata[95:0];
            cs_r     <= s_tdata[111:96];
            ce_r     <= in_ce;
            last_r   <= s_tlast;
            now_r    <= s_tdata[165:134];
            sidx     <= '0;
            cur      <= '0;
            found    <= 1'b0;
            free_ok  <= 1'b0;
            open_cnt <= '0;
            exp_cnt  <= '0;
            res_ks   <= 16'd0;
            res_ke   <= 16'd0;
            res_tot  <= 16'd0;
            state    <= s_tuser ? S_TICK : S_SEARCH;
          end
        end

        S_TICK: begin
          if (ctx_valid[sidx] && now_r > ctx_expiry[sidx]) begin
            ctx_valid[sidx] <= 1'b0;
            exp_cnt <= exp_cnt + OW'(1);
          end
          if (32'(sidx) == CONTEXTS - 1) begin
            res_verdict <= ifr_pkg::V_TICK;
            state <= S_FIN;
          end
          sidx <= sidx + CTX_W'(1);
        end

        S_SEARCH: begin
          if (ctx_valid[sidx]) begin
            open_cnt <= open_cnt + OW'(1);
            if (ctx_key[sidx] == key_r) begin
              found <= 1'b1;
              cur   <= sidx;
            end
          end else if (!free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= sidx;
          end
          if ((ctx_valid[sidx] && ctx_key[sidx] == key_r) || 32'(sidx) == CONTEXTS - 1)
            state <= S_DECIDE;
          sidx <= sidx + CTX_W'(1);
        end

        S_DECIDE: begin
          if (!found) begin
            if (32'(open_cnt) < 32'(max_ctx) && free_ok) begin
              found                   <= 1'b1;
              cur                     <= free_idx;
              ctx_valid[free_idx]     <= 1'b1;
              ctx_key[free_idx]       <= key_r;
              ctx_last_seen[free_idx] <= 1'b0;
              ctx_total[free_idx]     <= 16'd0;
              ctx_sum[free_idx]       <= 5'd0;
              ctx_expiry[free_idx]    <= now_r + timeout;
              span_n[free_idx]        <= '0;
            end else begin
              res_verdict <= ifr_pkg::V_NO_CTX;
              state <= S_FIN;
            end
          end else if (32'(ctx_sum[cur]) >= 32'(max_frags)) begin
            ctx_valid[cur] <= 1'b0;
            res_verdict <= ifr_pkg::V_FLUSH;
            state <= S_FIN;
          end else if (last_r && ctx_last_seen[cur]) begin
            res_verdict <= ifr_pkg::V_REPEAT;
            state <= S_FIN;
          end else begin
            if (last_r) begin
              ctx_last_seen[cur] <= 1'b1;
              ctx_total[cur]     <= ce_r;
            end
            n_old  <= span_n[cur];
            p      <= span_n[cur];
            ld_i   <= '0;
            kb     <= '0;
            pfound <= 1'b0;
            rem    <= '0;
            state  <= S_LOAD;
          end
        end

        S_LOAD: begin
          if (issue) ld_i <= ld_i + NW'(1);
          if (rd_v) begin
            w_span[rd_i[IW-1:0]] <= mem_rdata;
            if (!pfound) begin
              if (ce_r < mem_rdata.span_end) begin
                pfound <= 1'b1;
                p      <= rd_i;
                nxt    <= mem_rdata;
                if (last_r) rem <= rem + RW'(mem_rdata.cnt);
              end else if (mem_rdata.span_start <= cs_r) begin
                kb  <= rd_i + NW'(1);
                prv <= mem_rdata;
              end else begin
                rem <= rem + RW'(mem_rdata.cnt);
              end
            end else if (last_r) begin
              rem <= rem + RW'(mem_rdata.cnt);
            end
          end
          if (!issue && !rd_v) state <= S_PLAN;
        end

        S_PLAN: begin
          h_r     <= h_c;
          t_r     <= t_c;
          hasm_r  <= hasm_c;
          new_n_r <= new_n_c;
          m_r     <= pout.m;
          j       <= '0;
          if (full_c) begin
            ctx_valid[cur] <= 1'b0;
            res_verdict <= ifr_pkg::V_FLUSH;
            state  <= S_FIN;
          end else begin
            span_n[cur]  <= new_n_c;
            ctx_sum[cur] <= sum_new;
            if (pout.dup) begin
              res_verdict <= ifr_pkg::V_DUP;
            end else begin
              res_ks <= pout.kcs;
              res_ke <= pout.kce;
              if (complete_c) begin
                res_verdict <= ifr_pkg::V_COMPLETE;
                res_tot <= ctx_total[cur];
                ctx_valid[cur] <= 1'b0;
              end else begin
                res_verdict <= pout.trimmed ? ifr_pkg::V_TRIMMED : ifr_pkg::V_STORED;
              end
            end
            state <= (complete_c || new_n_c == '0) ? S_FIN : S_WRITE;
          end
        end

        S_WRITE: begin
          j <= j + NW'(1);
          if (j == new_n_r - NW'(1)) state <= S_FIN;
        end

        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_verdict;
            m_tdata  <= {7'd0,
                         (res_verdict == ifr_pkg::V_TICK) ? exp32[4:0] : 5'd0,
                         (res_verdict == ifr_pkg::V_TICK ||
                          res_verdict == ifr_pkg::V_NO_CTX) ? 4'd0 : cur32[3:0],
                         res_tot, res_ke, res_ks};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after an item was taken");

  a_complete_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ifr_pkg::V_COMPLETE |-> m_tdata[31:16] <= m_tdata[47:32])
    else $error("completed fragment ends past datagram length");

  a_tick_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ifr_pkg::V_TICK |-> m_tdata[51:0] == 52'd0)
    else $error("tick result carries fragment fields");

  a_frag_no_expiry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ifr_pkg::V_TICK |-> m_tdata[56:52] == 5'd0)
    else $error("fragment result reports expired contexts");

endmodule
